FILE: rtl/stmu_pkg.sv
// Shared constants, codes, result type and helpers for the software timer manager.
package stmu_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TICK_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 32;
  localparam int KIND_W  = 3;
  localparam int REM_W   = 32;

  localparam int MAX_IDS    = 1 << ID_W;
  localparam int SCAN_SLOTS = (NUM_TIMERS < MAX_IDS) ? NUM_TIMERS : MAX_IDS;
  localparam int SLOT_W     = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STARTED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOPPED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [REM_W-1:0]  rem;
    logic              active;
    logic              last;
  } res_t;

  // delay cut (or widened) to the counter width
  function automatic logic [TICK_WIDTH-1:0] to_tick(input logic [DELAY_W-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[TICK_WIDTH-1:0];
  endfunction

  // remaining count saturated to the result width
  function automatic logic [REM_W-1:0] sat_rem(input logic [TICK_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    if (w > 64'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return w[REM_W-1:0];
  endfunction

endpackage

FILE: rtl/stmu_outreg.sv
// Output register between the timer engine and the result channel.
module stmu_outreg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  stmu_pkg::res_t                push_res,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stmu_pkg::KIND_W-1:0]   kind,
  output logic [stmu_pkg::ID_W-1:0]     timer_id_res,
  output logic [stmu_pkg::REM_W-1:0]    remaining,
  output logic                          active,
  output logic                          last
);

  stmu_pkg::res_t data;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_res;
    end
  end

  assign kind         = data.kind;
  assign timer_id_res = data.id;
  assign remaining    = data.rem;
  assign active       = data.active;
  assign last         = data.last;

endmodule

FILE: rtl/stmu_engine.sv
// Timer engine: command sequencer, slot scan and timer memory.
module stmu_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [stmu_pkg::CMD_W-1:0]     cmd,
  input  logic [stmu_pkg::ID_W-1:0]      timer_id,
  input  logic [stmu_pkg::DELAY_W-1:0]   delay,
  input  logic                           periodic,
  output logic                           push,
  output stmu_pkg::res_t                 push_res,
  input  logic                           free
);

  localparam int TW = stmu_pkg::TICK_WIDTH;
  localparam int SW = stmu_pkg::SLOT_W;
  localparam int IW = stmu_pkg::ID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_QRY  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  typedef struct packed {
    logic [TW-1:0] expiry;
    logic [TW-1:0] period;
    logic          rep;
  } tword_t;

  tword_t mem [stmu_pkg::SCAN_SLOTS];
  tword_t rd_data;
  tword_t wr_data;

  logic [1:0]                       state;
  logic [SW-1:0]                    slot;
  logic [TW-1:0]                    tick_count;
  logic [stmu_pkg::SCAN_SLOTS-1:0]  armed;
  logic                             held;
  stmu_pkg::res_t                   hold;

  logic          in_fire;
  logic          id_ok;
  logic [SW-1:0] id_slot;
  logic [TW-1:0] dly;
  logic          due;
  logic          rearm;
  logic          scan_stall;
  logic          last_slot;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [TW-1:0] diff;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign id_ok      = {1'b0, timer_id} < (IW + 1)'(stmu_pkg::SCAN_SLOTS);
  assign id_slot    = timer_id[SW-1:0];
  assign dly        = stmu_pkg::to_tick(delay);
  assign due        = armed[slot] && (rd_data.expiry <= tick_count);
  assign rearm      = rd_data.rep && (rd_data.period != '0);
  assign scan_stall = due && held && !free;
  assign last_slot  = (slot == SW'(stmu_pkg::SCAN_SLOTS - 1));
  assign diff       = rd_data.expiry - tick_count;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = slot;
    wr_en    = 1'b0;
    wr_addr  = id_slot;
    wr_data  = '0;
    push     = 1'b0;
    push_res = hold;
    push_res.last = (state == ST_EMIT);
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == stmu_pkg::CMD_TICK) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
          if (cmd == stmu_pkg::CMD_QUERY && id_ok) begin
            rd_en   = 1'b1;
            rd_addr = id_slot;
          end
          if (cmd == stmu_pkg::CMD_START && id_ok && dly != '0) begin
            wr_en          = 1'b1;
            wr_data.expiry = tick_count + dly;
            wr_data.period = periodic ? dly : '0;
            wr_data.rep    = periodic;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_stall) begin
          // rewrite of this slot and read of the next never share an entry
          if (due && rearm) begin
            wr_en          = 1'b1;
            wr_addr        = slot;
            wr_data.expiry = tick_count + rd_data.period;
            wr_data.period = rd_data.period;
            wr_data.rep    = rd_data.rep;
          end
          push = due && held;
          if (!last_slot) begin
            rd_en   = 1'b1;
            rd_addr = slot + SW'(1);
          end
        end
      end
      ST_QRY: begin
      end
      ST_EMIT: begin
        push = free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot       <= '0;
      tick_count <= '0;
      armed      <= '0;
      held       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            hold.id   <= timer_id;
            hold.rem  <= '0;
            hold.last <= 1'b0;
            held      <= (cmd != stmu_pkg::CMD_TICK);
            case (cmd)
              stmu_pkg::CMD_TICK: begin
                tick_count <= tick_count + TW'(1);
                slot       <= '0;
                state      <= ST_SCAN;
              end
              stmu_pkg::CMD_START: begin
                if (id_ok && dly != '0) begin
                  armed[id_slot] <= 1'b1;
                  hold.kind      <= stmu_pkg::KIND_STARTED;
                  hold.active    <= 1'b1;
                end else begin
                  hold.kind   <= stmu_pkg::KIND_REJECTED;
                  hold.active <= id_ok && armed[id_slot];
                end
                state <= ST_EMIT;
              end
              stmu_pkg::CMD_STOP: begin
                if (id_ok) begin
                  armed[id_slot] <= 1'b0;
                end
                hold.kind   <= stmu_pkg::KIND_STOPPED;
                hold.active <= 1'b0;
                state       <= ST_EMIT;
              end
              default: begin
                hold.kind   <= stmu_pkg::KIND_QUERY;
                hold.active <= id_ok && armed[id_slot];
                state       <= ST_QRY;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!scan_stall) begin
            if (due) begin
              if (!rearm) begin
                armed[slot] <= 1'b0;
              end
              hold.kind   <= stmu_pkg::KIND_EXPIRED;
              hold.id     <= IW'(slot);
              hold.rem    <= '0;
              hold.active <= rearm;
              hold.last   <= 1'b0;
              held        <= 1'b1;
            end
            if (last_slot) begin
              if (!due && !held) begin
                hold.kind   <= stmu_pkg::KIND_IDLE_TICK;
                hold.id     <= '0;
                hold.rem    <= '0;
                hold.active <= 1'b0;
                hold.last   <= 1'b0;
                held        <= 1'b1;
              end
              state <= ST_EMIT;
            end else begin
              slot <= slot + SW'(1);
            end
          end
        end
        ST_QRY: begin
          if (hold.active && rd_data.expiry > tick_count) begin
            hold.rem <= stmu_pkg::sat_rem(diff);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (free) begin
            held  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> free)
    else $error("result pushed into a full output register");
  a_tick_inc: assert property (@(posedge clk) disable iff (rst)
    in_fire && cmd == stmu_pkg::CMD_TICK |=> tick_count == $past(tick_count) + TW'(1))
    else $error("tick count not advanced by a tick");
  a_emit_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> held)
    else $error("final result stage entered with nothing held");
  a_scan_wr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && wr_en |-> wr_addr == slot && due)
    else $error("scan rewrite outside the checked slot");
`endif

endmodule

FILE: rtl/software_timer_manager_unit.sv
// Top level of the software timer manager.
// Start, stop: the result passes from the emit state into the output register; a query
// reads its timer first. Tick: one timer slot checked per cycle from memory, 16 slots, while
// the output register can take each expiry result; its final result follows the scan.
// One command at a time: a new transfer is taken only after the final result is pushed.
// Reset (synchronous, active high) clears the tick count, armed flags and result valid.
module software_timer_manager_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [stmu_pkg::CMD_W-1:0]     cmd,
  input  logic [stmu_pkg::ID_W-1:0]      timer_id,
  input  logic [stmu_pkg::DELAY_W-1:0]   delay,
  input  logic                           periodic,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stmu_pkg::KIND_W-1:0]    kind,
  output logic [stmu_pkg::ID_W-1:0]      timer_id_res,
  output logic [stmu_pkg::REM_W-1:0]     remaining,
  output logic                           active,
  output logic                           last
);

  logic           push;
  logic           free;
  stmu_pkg::res_t push_res;

  stmu_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .timer_id (timer_id),
    .delay    (delay),
    .periodic (periodic),
    .push     (push),
    .push_res (push_res),
    .free     (free)
  );

  stmu_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_res     (push_res),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .timer_id_res (timer_id_res),
    .remaining    (remaining),
    .active       (active),
    .last         (last)
  );

endmodule

FILE: bench/software_timer_manager_unit_test.sv
// Self-checking bench for the software timer manager: directed table, random commands, scoreboard.
`timescale 1ns / 1ps

module software_timer_manager_unit_test;

  localparam int RANDOM_CMDS = 350;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IW = stmu_pkg::ID_W;
  localparam int DW = stmu_pkg::DELAY_W;
  localparam int TW = stmu_pkg::TICK_WIDTH;

  typedef struct {
    logic [stmu_pkg::CMD_W-1:0]   op;
    logic [stmu_pkg::ID_W-1:0]    slot;
    logic [stmu_pkg::DELAY_W-1:0] ticks;
    logic                         rep;
    bit                           known;
    stmu_pkg::res_t               want;
  } stim_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [stmu_pkg::CMD_W-1:0]    cmd;
  logic [stmu_pkg::ID_W-1:0]     timer_id;
  logic [stmu_pkg::DELAY_W-1:0]  delay;
  logic                          periodic;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [stmu_pkg::KIND_W-1:0]   kind;
  logic [stmu_pkg::ID_W-1:0]     timer_id_res;
  logic [stmu_pkg::REM_W-1:0]    remaining;
  logic                          active;
  logic                          last;

  // typed expectation travelling with the command on the input channel
  bit                            row_known;
  stmu_pkg::res_t                row_want;

  // predicted timer bank
  logic [stmu_pkg::TICK_WIDTH-1:0] now_ticks;
  logic [stmu_pkg::TICK_WIDTH-1:0] due_at [stmu_pkg::NUM_TIMERS];
  logic [stmu_pkg::TICK_WIDTH-1:0] reload_ticks [stmu_pkg::NUM_TIMERS];
  logic                            rearms [stmu_pkg::NUM_TIMERS];
  logic                            armed [stmu_pkg::NUM_TIMERS];
  stmu_pkg::res_t                  awaited_results [$];

  stmu_pkg::res_t got, want;
  int   fail_count = 0;
  int   commands_in = 0;
  int   ticks_in = 0;
  int   results_seen = 0;
  int   expiries_seen = 0;
  int   rearms_seen = 0;
  int   idle_cycles = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  int   rx_phase = 0;

  software_timer_manager_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .timer_id(timer_id), .delay(delay), .periodic(periodic),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .timer_id_res(timer_id_res), .remaining(remaining),
    .active(active), .last(last)
  );

  always #5 clk = ~clk;

  function automatic stim_t row(input logic [stmu_pkg::CMD_W-1:0] op,
                                input logic [stmu_pkg::ID_W-1:0] slot,
                                input logic [stmu_pkg::DELAY_W-1:0] ticks, input logic rep,
                                input bit known = 1'b0,
                                input logic [stmu_pkg::KIND_W-1:0] k = stmu_pkg::KIND_EXPIRED,
                                input logic [stmu_pkg::REM_W-1:0] rem = '0,
                                input logic act = 1'b0);
    stim_t r;
    r.op = op;
    r.slot = slot;
    r.ticks = ticks;
    r.rep = rep;
    r.known = known;
    r.want = '{k, slot, rem, act, 1'b1};
    return r;
  endfunction

  function automatic void clear_timer_bank();
    now_ticks = '0;
    for (int s = 0; s < stmu_pkg::NUM_TIMERS; s++) begin
      due_at[s] = '0;
      reload_ticks[s] = '0;
      rearms[s] = 1'b0;
      armed[s] = 1'b0;
    end
  endfunction

  // advance the predicted bank by one command and queue the results it causes
  function automatic void apply_timer_command(input logic [stmu_pkg::CMD_W-1:0] op,
                                              input logic [stmu_pkg::ID_W-1:0] slot,
                                              input logic [stmu_pkg::DELAY_W-1:0] ticks,
                                              input logic rep);
    stmu_pkg::res_t                  batch [$];
    stmu_pkg::res_t                  r;
    bit                              in_bank;
    logic [stmu_pkg::TICK_WIDTH-1:0] span;
    logic [stmu_pkg::TICK_WIDTH-1:0] left;
    in_bank = int'(slot) < stmu_pkg::SCAN_SLOTS;
    span = TW'(ticks);
    case (op)
      stmu_pkg::CMD_TICK: begin
        now_ticks = now_ticks + 1'b1;
        for (int s = 0; s < stmu_pkg::SCAN_SLOTS; s++) begin
          if (armed[s] && due_at[s] <= now_ticks) begin
            if (rearms[s] && reload_ticks[s] != '0) begin
              due_at[s] = now_ticks + reload_ticks[s];
              rearms_seen++;
            end else begin
              armed[s] = 1'b0;
            end
            batch.push_back('{stmu_pkg::KIND_EXPIRED, IW'(s), '0, armed[s], 1'b0});
          end
        end
        if (batch.size() == 0)
          batch.push_back('{stmu_pkg::KIND_IDLE_TICK, '0, '0, 1'b0, 1'b0});
      end
      stmu_pkg::CMD_START: begin
        if (!in_bank || span == '0) begin
          batch.push_back('{stmu_pkg::KIND_REJECTED, slot, '0, in_bank && armed[slot], 1'b0});
        end else begin
          due_at[slot] = now_ticks + span;
          reload_ticks[slot] = rep ? span : '0;
          rearms[slot] = rep;
          armed[slot] = 1'b1;
          batch.push_back('{stmu_pkg::KIND_STARTED, slot, '0, 1'b1, 1'b0});
        end
      end
      stmu_pkg::CMD_STOP: begin
        if (in_bank)
          armed[slot] = 1'b0;
        batch.push_back('{stmu_pkg::KIND_STOPPED, slot, '0, 1'b0, 1'b0});
      end
      default: begin
        if (in_bank && armed[slot] && due_at[slot] > now_ticks)
          left = due_at[slot] - now_ticks;
        else
          left = '0;
        batch.push_back('{stmu_pkg::KIND_QUERY, slot, stmu_pkg::sat_rem(left),
                          in_bank && armed[slot], 1'b0});
      end
    endcase
    foreach (batch[i]) begin
      r = batch[i];
      r.last = (i == batch.size() - 1);
      awaited_results.push_back(r);
    end
  endfunction

  task automatic note_mismatch(input string what, input stmu_pkg::res_t exp_r,
                               input stmu_pkg::res_t act_r);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected kind %0d id %0d rem %h active %b last %b",
               $time, what, exp_r.kind, exp_r.id, exp_r.rem, exp_r.active, exp_r.last);
      $display("%0t %s: got      kind %0d id %0d rem %h active %b last %b",
               $time, what, act_r.kind, act_r.id, act_r.rem, act_r.active, act_r.last);
    end
  endtask

  // scoreboard: outputs are checked before the same edge's input transfer is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{kind, timer_id_res, remaining, active, last};
        results_seen++;
        if (got.kind == stmu_pkg::KIND_EXPIRED)
          expiries_seen++;
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind || got.id !== want.id || got.rem !== want.rem ||
              got.active !== want.active || got.last !== want.last)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        apply_timer_command(cmd, timer_id, delay, periodic);
        if (row_known) begin
          void'(awaited_results.pop_back());
          awaited_results.push_back(row_want);
        end
        commands_in++;
        if (cmd == stmu_pkg::CMD_TICK)
          ticks_in++;
      end
    end
  end

  // receiver back-pressure: switches between steady, random and patterned stalls
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(20, 150);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_phase % 4) == 0;
      default: out_ready <= (rx_phase % 13) >= 10;
    endcase
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_t plan [$];
    int    burst_left;
    int    gap;
    int    pick;
    logic [stmu_pkg::DELAY_W-1:0] span;

    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= stmu_pkg::CMD_TICK;
    timer_id <= '0;
    delay <= '0;
    periodic <= 1'b0;
    row_known <= 1'b0;
    row_want <= '0;
    clear_timer_bank();

    // directed table
    plan.push_back(row(stmu_pkg::CMD_TICK,  4'd0,  32'd0, 1'b0, 1,
                       stmu_pkg::KIND_IDLE_TICK, '0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_QUERY, 4'd0,  32'd0, 1'b0, 1,
                       stmu_pkg::KIND_QUERY, '0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd0,  32'd0, 1'b1, 1,
                       stmu_pkg::KIND_REJECTED, '0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd3,  32'd1, 1'b0, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_QUERY, 4'd3,  32'd0, 1'b0, 1,
                       stmu_pkg::KIND_QUERY, 32'd1, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_TICK,  4'd3,  32'hFFFF_FFFF, 1'b1, 1,
                       stmu_pkg::KIND_EXPIRED, '0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd15, 32'd2, 1'b1, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    // sum wraps past the top of the counter: due on the next tick
    plan.push_back(row(stmu_pkg::CMD_START, 4'd0,  32'hFFFF_FFFF, 1'b0, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_QUERY, 4'd0,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd7,  32'd5, 1'b1, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd7,  32'd0, 1'b0, 1,
                       stmu_pkg::KIND_REJECTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_TICK,  4'd0,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_TICK,  4'd0,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_QUERY, 4'd15, 32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_STOP,  4'd15, 32'd0, 1'b0, 1,
                       stmu_pkg::KIND_STOPPED, '0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_STOP,  4'd9,  32'd0, 1'b0, 1,
                       stmu_pkg::KIND_STOPPED, '0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd8,  32'h8000_0000, 1'b1, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_QUERY, 4'd8,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd1,  32'd1, 1'b1, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd2,  32'd1, 1'b0, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd14, 32'd1, 1'b1, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));
    plan.push_back(row(stmu_pkg::CMD_TICK,  4'd0,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_TICK,  4'd0,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_QUERY, 4'd2,  32'd0, 1'b0));
    plan.push_back(row(stmu_pkg::CMD_START, 4'd4,  32'h5555_AAAA, 1'b1, 1,
                       stmu_pkg::KIND_STARTED, '0, 1'b1));

    // random commands: mostly short delays so timers keep firing
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        span = '0;
      else if (pick < 16)
        span = $urandom;
      else if (pick < 22)
        span = 32'hFFFF_FFFF - DW'($urandom_range(0, 3));
      else
        span = DW'($urandom_range(1, 12));
      pick = $urandom_range(0, 99);
      plan.push_back(row(pick < 36 ? stmu_pkg::CMD_TICK : pick < 70 ? stmu_pkg::CMD_START :
                         pick < 82 ? stmu_pkg::CMD_STOP : stmu_pkg::CMD_QUERY,
                         IW'($urandom_range(0, 15)), span, 1'($urandom_range(0, 1))));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    burst_left = 0;
    foreach (plan[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 10);
      end
      cmd <= plan[i].op;
      timer_id <= plan[i].slot;
      delay <= plan[i].ticks;
      periodic <= plan[i].rep;
      row_known <= plan[i].known;
      row_want <= plan[i].want;
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += awaited_results.size();

    $display("%0d commands (%0d ticks) sent, %0d results checked", commands_in, ticks_in,
             results_seen);
    $display("%0d timer expiries seen, %0d periodic rearms predicted, %0d failures",
             expiries_seen, rearms_seen, fail_count);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
